>>> hw/rtl/fde_pkg.sv
package fde_pkg;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // widest skip counter over the supported skip periods
    localparam int SKIP_K_W = 3;

    // reciprocal shift for the ramp divide
    localparam int DIV_SHIFT = 21;

    // result buffer depth, also the limit on requests in flight
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W      = 2;
    localparam int OUT_CNT_W      = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP  = 2'd2;

    // register reset values
    localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd24000;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // one request handed from the store loop to the wet path
    typedef struct packed {
        logic                valid;
        logic                skip;
        logic [SKIP_K_W-1:0] k;
        sample_t             x;
        sample_t             delayed;
    } fde_wet_req_t;

    // saturate a wide signed sum to one sample
    function automatic sample_t sat_sample(input logic signed [19:0] v);
        sample_t r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/fde_wet_path.sv
module fde_wet_path #(
    parameter int SKIP_PERIOD = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fde_pkg::fde_wet_req_t req,
    output logic                 out_valid,
    output fde_pkg::sample_t     out_sample
);
    import fde_pkg::*;

    localparam int DIVISOR = SKIP_PERIOD - 1;
    localparam longint MAGIC = ((64'd1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int MW = DIV_SHIFT + 1;
    localparam logic [MW-1:0] MAGIC_V = MW'(MAGIC);

    // stage a: k times delayed
    logic                a_valid_reg;
    logic                a_skip_reg;
    sample_t             a_x_reg;
    sample_t             a_dly_reg;
    logic signed [19:0]  a_kd_reg;

    // stage b: magnitude times reciprocal
    logic                b_valid_reg;
    logic                b_skip_reg;
    logic                b_neg_reg;
    sample_t             b_x_reg;
    sample_t             b_dly_reg;
    logic [18+MW:0]      b_prod_reg;

    // stage c: result
    logic                c_valid_reg;
    sample_t             c_sample_reg;

    logic [18:0]         kd_mag;
    logic [17:0]         quo;
    logic signed [19:0]  wet;
    logic signed [19:0]  sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= req.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // magnitude of the ramp product
    always_comb begin
        if (a_kd_reg < 0) begin
            kd_mag = 19'(-a_kd_reg);
        end else begin
            kd_mag = a_kd_reg[18:0];
        end
    end

    // truncating quotient, then dry plus wet
    always_comb begin
        quo = b_prod_reg[DIV_SHIFT +: 18];
        if (b_neg_reg) begin
            wet = -$signed({2'b00, quo});
        end else begin
            wet = $signed({2'b00, quo});
        end
        if (b_skip_reg) begin
            sum = 20'(b_x_reg) + wet;
        end else begin
            sum = 20'(b_x_reg) + 20'(b_dly_reg);
        end
    end

    always_ff @(posedge aclk) begin
        a_skip_reg   <= req.skip;
        a_x_reg      <= req.x;
        a_dly_reg    <= req.delayed;
        a_kd_reg     <= $signed({1'b0, req.k}) * req.delayed;

        b_skip_reg   <= a_skip_reg;
        b_x_reg      <= a_x_reg;
        b_dly_reg    <= a_dly_reg;
        b_neg_reg    <= (a_kd_reg < 0);
        b_prod_reg   <= kd_mag * MAGIC_V;

        c_sample_reg <= sat_sample(sum);
    end

    assign out_valid  = c_valid_reg;
    assign out_sample = c_sample_reg;

endmodule

>>> hw/rtl/fde_out_fifo.sv
module fde_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fde_pkg::sample_t push_data,
    input  logic             pop,
    output logic             not_empty,
    output fde_pkg::sample_t head
);
    import fde_pkg::*;

    sample_t              buf_reg [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = buf_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/feedback_delay_echo.sv
// channel   | dir | signals                                  | contents
// s_        | in  | s_tvalid s_tready s_tdata s_tuser        | sample_in, block_start
// m_        | out | m_tvalid m_tready m_tdata                | sample_out
// cfg_      | in  | cfg_valid cfg_ready cfg_index cfg_data   | register writes
//
// a new request is not taken while the last one is written back: the single-port delay store is read in the
// accept cycle and written back with the feedback sample in the next one
// a result passes write-back, hand-off, wet stages a, b, c and the buffer; up to 4 requests in flight
// reset is synchronous; the store needs no clearing pass, entries not yet
// written since reset read as zero through a fill mark on the write pointer
// a stalled result waits in a 4-entry buffer; the input flows until 4 requests are in flight
module feedback_delay_echo #(
    parameter int STORE_DEPTH = 131072,
    parameter int SKIP_PERIOD = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fde_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample_in
    input  logic                              s_tuser,   // [0] block_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fde_pkg::SAMPLE_W-1:0]      m_tdata,   // [15:0] sample_out
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fde_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import fde_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam int KW = $clog2(SKIP_PERIOD);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [CW-1:0] DMAX_C  = CW'(STORE_DEPTH - 1);
    localparam logic [KW:0]   PERIOD_C = (KW + 1)'(SKIP_PERIOD);

    // configuration registers
    logic [DELAY_W-1:0] delay_samples_reg;
    logic [GAIN_W-1:0]  feedback_gain_reg;
    logic               skip_enable_reg;

    // store loop state
    logic [AW-1:0]      wp_reg;
    logic               wrapped_reg;
    logic [KW-1:0]      skip_cnt_reg;
    logic [KW-1:0]      skip_cnt_next;
    logic [OUT_CNT_W-1:0] inflight_reg;

    // write-back phase
    logic               wb_valid_reg;
    logic [AW-1:0]      wb_addr_reg;
    logic               wb_rd_ok_reg;
    sample_t            wb_x_reg;
    logic               wb_skip_reg;
    logic [KW-1:0]      wb_k_reg;

    sample_t            store_mem [STORE_DEPTH];
    sample_t            rd_data_reg;

    logic               s_accept;
    logic               m_accept;
    logic [CW-1:0]      dly;
    logic [CW-1:0]      wp_ext;
    logic [CW-1:0]      rd_ext;
    logic [AW-1:0]      rd_addr;
    logic               rd_ok;
    logic [KW-1:0]      k_cur;
    logic [KW:0]        k_inc;

    sample_t            delayed;
    logic signed [32:0] fb_prod;
    logic signed [19:0] fb_sum;
    sample_t            fb_sample;

    fde_wet_req_t       wet_req_reg;
    logic               wet_valid;
    sample_t            wet_sample;

    assign cfg_ready = 1'b1;
    assign s_tready  = !wb_valid_reg && (inflight_reg != OUT_CNT_W'(OUT_FIFO_DEPTH));
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_samples_reg <= DELAY_RESET;
            feedback_gain_reg <= GAIN_RESET;
            skip_enable_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DELAY: delay_samples_reg <= cfg_data[DELAY_W-1:0];
                REG_GAIN:  feedback_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_SKIP:  skip_enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp delay and form read address
    always_comb begin
        dly = CW'(delay_samples_reg);
        if (dly == '0) begin
            dly = CW'(1);
        end else if (dly > DMAX_C) begin
            dly = DMAX_C;
        end
        wp_ext = CW'(wp_reg);
        if (wp_ext >= dly) begin
            rd_ext = wp_ext - dly;
        end else begin
            rd_ext = wp_ext + DEPTH_C - dly;
        end
        rd_addr = rd_ext[AW-1:0];
        rd_ok   = wrapped_reg || (rd_addr < wp_reg);
    end

    // ramp counter
    always_comb begin
        k_cur = s_tuser ? '0 : skip_cnt_reg;
        k_inc = {1'b0, k_cur} + 1'b1;
        if (skip_enable_reg) begin
            skip_cnt_next = (k_inc == PERIOD_C) ? '0 : k_inc[KW-1:0];
        end else begin
            skip_cnt_next = k_cur;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            skip_cnt_reg <= '0;
            wb_valid_reg <= 1'b0;
            inflight_reg <= '0;
        end else begin
            wb_valid_reg <= s_accept;
            if (s_accept) begin
                skip_cnt_reg <= skip_cnt_next;
                if (CW'(wp_reg) == DMAX_C) begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
            if (s_accept && !m_accept) begin
                inflight_reg <= inflight_reg + 1'b1;
            end else if (m_accept && !s_accept) begin
                inflight_reg <= inflight_reg - 1'b1;
            end
        end
    end

    // request fields held for write-back
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            wb_addr_reg  <= wp_reg;
            wb_rd_ok_reg <= rd_ok;
            wb_x_reg     <= s_tdata;
            wb_skip_reg  <= skip_enable_reg;
            wb_k_reg     <= k_cur;
        end
    end

    // delay store, one port: read on accept, write back the cycle after
    always_ff @(posedge aclk) begin
        if (wb_valid_reg) begin
            store_mem[wb_addr_reg] <= fb_sample;
        end else if (s_accept) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // feedback sample: floor of gain times delayed, plus input, saturated
    always_comb begin
        delayed   = wb_rd_ok_reg ? rd_data_reg : '0;
        fb_prod   = $signed({1'b0, feedback_gain_reg}) * delayed;
        fb_sum    = 20'(wb_x_reg) + 20'($signed(fb_prod[32:16]));
        fb_sample = sat_sample(fb_sum);
    end

    // hand off to wet path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_req_reg.valid <= 1'b0;
        end else begin
            wet_req_reg.valid <= wb_valid_reg;
        end
        wet_req_reg.skip    <= wb_skip_reg;
        wet_req_reg.k       <= SKIP_K_W'(wb_k_reg);
        wet_req_reg.x       <= wb_x_reg;
        wet_req_reg.delayed <= delayed;
    end

    fde_wet_path #(
        .SKIP_PERIOD(SKIP_PERIOD)
    ) u_wet (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (wet_req_reg),
        .out_valid (wet_valid),
        .out_sample(wet_sample)
    );

    fde_out_fifo u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (wet_valid),
        .push_data(wet_sample),
        .pop      (m_accept),
        .not_empty(m_tvalid),
        .head     (m_tdata)
    );

endmodule

>>> tb/fde_checker.sv
`timescale 1ns / 1ps

module fde_checker
    import fde_pkg::*;
#(
    parameter int STORE_DEPTH = 131072,
    parameter int SKIP_PERIOD = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
    input  logic                 s_tuser,   // [0] block_start
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   errors,
    output int                   outstanding
);

    // shadow copy of the echo state
    sample_t            echo_store [STORE_DEPTH];
    int                 wr_ptr;
    int                 ramp_k;
    logic [DELAY_W-1:0] delay_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               skip_reg;

    // echo samples still owed by the block, oldest first
    sample_t echo_queue [$];

    function automatic sample_t clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return sample_t'(v);
    endfunction

    // one sample through the delay line, updates the shadow state
    function automatic sample_t predict_echo(input sample_t x, input logic start);
        int      dly;
        int      rd_idx;
        sample_t delayed;
        longint  prod;
        longint  fb;
        int      k;
        int      wet;
        sample_t y;
        dly = int'(delay_reg);
        if (dly < 1) dly = 1;
        if (dly > STORE_DEPTH - 1) dly = STORE_DEPTH - 1;
        rd_idx  = (wr_ptr + STORE_DEPTH - dly) % STORE_DEPTH;
        delayed = echo_store[rd_idx];
        // feedback product, arithmetic shift gives floor
        prod = longint'(gain_reg) * longint'(delayed);
        fb   = prod >>> 16;
        echo_store[wr_ptr] = clamp16(longint'(x) + fb);
        k = start ? 0 : ramp_k % SKIP_PERIOD;
        if (skip_reg) begin
            // int divide truncates toward zero
            wet    = (k * int'(delayed)) / (SKIP_PERIOD - 1);
            y      = clamp16(longint'(x) + longint'(wet));
            ramp_k = (k + 1) % SKIP_PERIOD;
        end else begin
            y      = clamp16(longint'(x) + longint'(delayed));
            ramp_k = k;
        end
        wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
        return y;
    endfunction

    task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
        $display("mismatch at %0t: %s, got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // watch register writes, requests and results
    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            foreach (echo_store[i]) echo_store[i] = '0;
            wr_ptr    = 0;
            ramp_k    = 0;
            delay_reg = DELAY_RESET;
            gain_reg  = GAIN_RESET;
            skip_reg  = 1'b0;
            echo_queue.delete();
            errors    = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DELAY: delay_reg = cfg_data[DELAY_W-1:0];
                    REG_GAIN:  gain_reg  = cfg_data[GAIN_W-1:0];
                    REG_SKIP:  skip_reg  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                echo_queue.push_back(predict_echo(sample_t'(s_tdata), s_tuser));
            end
            if (m_tvalid && m_tready) begin
                if (echo_queue.size() == 0) begin
                    report_mismatch("result with no request outstanding",
                                    sample_t'(m_tdata), '0);
                end else begin
                    want = echo_queue.pop_front();
                    if (sample_t'(m_tdata) !== want) begin
                        report_mismatch("sample_out", sample_t'(m_tdata), want);
                    end
                end
            end
            outstanding <= echo_queue.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fde_pkg::*;

    localparam int DEPTH           = 131072;
    localparam int PERIOD          = 8;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RAND_SETTINGS   = 6;
    localparam int ITEMS_PER_SET   = 72;

    // index past the last register, the block ignores it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;   // [15:0] sample_in
    logic                 s_tuser   = 1'b0; // [0] block_start
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;          // [15:0] sample_out
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int   send_idle     = 36;
    int   recv_idle     = 62;
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    int   fail_count;
    int   outstanding;

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    feedback_delay_echo #(
        .STORE_DEPTH(DEPTH),
        .SKIP_PERIOD(PERIOD)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fde_checker #(
        .STORE_DEPTH(DEPTH),
        .SKIP_PERIOD(PERIOD)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (fail_count),
        .outstanding (outstanding)
    );

    // result side: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // run limit
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_sample(input sample_t x, input logic start);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait until every echo sample is back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(0, 127)) - 64);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        int                 s;
        int                 n;
        int                 len;
        logic [DELAY_W-1:0] dly;
        logic [GAIN_W-1:0]  gain;
        logic [CFG_DAT_W-1:0] word;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero delay acts as one, full-scale gain through dropped upper bit
        write_reg(REG_DELAY, '0);
        write_reg(REG_GAIN, 17'h1ffff);
        write_reg(REG_SKIP, 17'h1fffe);
        write_reg(REG_SPARE, 17'h15a5a);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b1);

        // ramp mode: counter climbs from a block start, block start mid-run
        settle();
        write_reg(REG_DELAY, 17'd2);
        write_reg(REG_GAIN, 17'd62259);
        write_reg(REG_SKIP, 17'h10003);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd1000, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd13, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);

        // counter holds while ramp mode is off
        settle();
        write_reg(REG_SKIP, '0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        settle();
        write_reg(REG_SKIP, 17'd1);
        send_sample(SAMPLE_MIN, 1'b0);

        // random settings, each a run of sample blocks
        for (s = 0; s < RAND_SETTINGS; s++) begin
            settle();
            if (s == 2) begin
                send_idle <= 62;
                recv_idle <= 36;
            end else if (s == 4) begin
                send_idle <= 0;
                recv_idle <= 0;
                hold_off_req <= 1'b1;
            end
            case (s)
                0:       dly = DELAY_W'($urandom_range(1, 12));
                1:       dly = 17'h1ffff;
                2:       dly = '0;
                3:       dly = DELAY_W'($urandom);
                4:       dly = DELAY_W'($urandom_range(1, 40));
                default: dly = DELAY_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 3))
                0:       gain = '0;
                1:       gain = 16'hffff;
                2:       gain = 16'd62259;
                default: gain = GAIN_W'($urandom);
            endcase
            write_reg(REG_DELAY, dly);
            write_reg(REG_GAIN, {1'($urandom), gain});
            word    = CFG_DAT_W'($urandom);
            word[0] = (s % 2 == 0);
            write_reg(REG_SKIP, word);
            write_reg(REG_SPARE, CFG_DAT_W'($urandom));
            n = 0;
            while (n < ITEMS_PER_SET) begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len && n < ITEMS_PER_SET; i++) begin
                    // mostly clean blocks, some stray block starts
                    if ($urandom_range(0, 9) == 0) begin
                        send_sample(pick_sample(), 1'($urandom));
                    end else begin
                        send_sample(pick_sample(), i == 0);
                    end
                    n++;
                end
            end
        end

        // drain and verdict
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
